/* rtl/str_pkg.sv */
// shared types and constants for the trapezoid ramp stepper core
// no dependencies; used by str_cfg, str_engine and the top level
`default_nettype none

package str_pkg;

    // default for the move length field width
    localparam int STEP_COUNT_BITS_DEF = 12;

    // configuration port geometry and register indexes
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_DELAY = 8'd1;

    // register reset values
    localparam logic [7:0] START_DELAY_RST  = 8'd17;
    localparam logic [7:0] CRUISE_DELAY_RST = 8'd5;

    localparam logic [7:0] DELAY_MAX = 8'hFF;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // four-phase coil sequence, clockwise order
    localparam logic [5:0] COIL_TABLE [4] = '{6'h36, 6'h2E, 6'h2D, 6'h35};

    // one result word
    typedef struct packed {
        logic [5:0] coil_pattern;
        logic       step_taken;
        logic       busy_res;
        logic       move_done;
    } t_result;

endpackage

`default_nettype wire

/* rtl/str_cfg.sv */
// configuration registers: start delay and cruise delay
// depends on str_pkg
`default_nettype none

module str_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [str_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [str_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic                                  o_cfg_ready,
    output logic [7:0]                            o_start_delay,
    output logic [7:0]                            o_cruise_delay
);

    logic [7:0] r_start_delay;
    logic [7:0] r_cruise_delay;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // register file with decoded write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delay  <= str_pkg::START_DELAY_RST;
            r_cruise_delay <= str_pkg::CRUISE_DELAY_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                str_pkg::CFG_START_DELAY:  r_start_delay  <= i_cfg_wdata;
                str_pkg::CFG_CRUISE_DELAY: r_cruise_delay <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_start_delay  = r_start_delay;
    assign o_cruise_delay = r_cruise_delay;

endmodule

`default_nettype wire

/* rtl/str_engine.sv */
// move state registers and the single-pass ramp / phase update for one word
// depends on str_pkg
`default_nettype none

module str_engine #(
    parameter int STEP_COUNT_BITS = str_pkg::STEP_COUNT_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic                        i_cmd,
    input  wire logic                        i_dir,
    input  wire logic [STEP_COUNT_BITS-1:0]  i_count,
    input  wire logic [7:0]                  i_start_delay,
    input  wire logic [7:0]                  i_cruise_delay,
    output str_pkg::t_result                 o_result
);

    localparam int CW = STEP_COUNT_BITS;

    logic [1:0]    r_phase,        n_phase;
    logic          r_direction,    n_direction;
    logic [CW-1:0] r_total_steps,  n_total_steps;
    logic [CW-1:0] r_step_number,  n_step_number;
    logic [7:0]    r_cur_delay,    n_cur_delay;
    logic [CW-1:0] r_accel_steps,  n_accel_steps;
    logic          r_accelerating, n_accelerating;
    logic [7:0]    r_ticks_left,   n_ticks_left;
    logic          r_moving,       n_moving;
    logic [5:0]    r_coil,         n_coil;

    logic          is_start;
    logic          is_tick;
    logic [7:0]    tl_dec;
    logic          do_step;
    logic          done;

    // step source: fresh move values on a start, live state on a tick
    logic          s_dir;
    logic [CW-1:0] s_total;
    logic [CW-1:0] s_stepn;
    logic [7:0]    s_delay;
    logic [CW-1:0] s_accel;
    logic          s_accelerating;
    logic [CW-1:0] s_left;

    // command decode
    assign is_start = (i_cmd == str_pkg::CMD_START) && !r_moving && (i_count != '0);
    assign is_tick  = (i_cmd == str_pkg::CMD_TICK) && r_moving;
    assign tl_dec   = (r_ticks_left != 8'd0) ? r_ticks_left - 8'd1 : 8'd0;
    assign do_step  = is_start
                   || (is_tick && (tl_dec == 8'd0) && (r_step_number < r_total_steps));
    assign done     = ((i_cmd == str_pkg::CMD_START) && !r_moving && (i_count == '0))
                   || (is_tick && (tl_dec == 8'd0) && !(r_step_number < r_total_steps));

    assign s_dir          = is_start ? i_dir : r_direction;
    assign s_total        = is_start ? i_count : r_total_steps;
    assign s_stepn        = is_start ? '0 : r_step_number;
    assign s_delay        = is_start ? i_start_delay : r_cur_delay;
    assign s_accel        = is_start ? '0 : r_accel_steps;
    assign s_accelerating = is_start ? 1'b1 : r_accelerating;
    assign s_left         = s_total - s_stepn;

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_direction    = r_direction;
        n_total_steps  = r_total_steps;
        n_step_number  = r_step_number;
        n_cur_delay    = r_cur_delay;
        n_accel_steps  = r_accel_steps;
        n_accelerating = r_accelerating;
        n_ticks_left   = r_ticks_left;
        n_moving       = r_moving;
        n_coil         = r_coil;
        if (do_step) begin
            n_direction    = s_dir;
            n_total_steps  = s_total;
            n_accel_steps  = s_accel;
            n_accelerating = s_accelerating;
            n_cur_delay    = s_delay;
            n_moving       = 1'b1;
            // ramp: accelerate, cruise, then decelerate with saturation
            if (s_accelerating && (s_delay > i_cruise_delay)) begin
                n_cur_delay   = s_delay - 8'd1;
                n_accel_steps = s_accel + CW'(1);
            end else if (s_left > s_accel) begin
                n_cur_delay = s_delay;
            end else begin
                n_accelerating = 1'b0;
                if (s_delay != str_pkg::DELAY_MAX) begin
                    n_cur_delay = s_delay + 8'd1;
                end
            end
            // coil pattern, mirrored for counter-clockwise
            if (s_dir) begin
                n_coil = str_pkg::COIL_TABLE[r_phase];
            end else begin
                n_coil = str_pkg::COIL_TABLE[2'd3 - r_phase];
            end
            n_phase       = r_phase + 2'd1;
            n_step_number = s_stepn + CW'(1);
            n_ticks_left  = (s_delay == 8'd0) ? 8'd1 : s_delay;
        end else if (is_tick) begin
            n_ticks_left = tl_dec;
            if (done) begin
                n_moving = 1'b0;
            end
        end
    end

    // state registers, updated only on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= 2'd0;
            r_direction    <= 1'b0;
            r_total_steps  <= '0;
            r_step_number  <= '0;
            r_cur_delay    <= 8'd0;
            r_accel_steps  <= '0;
            r_accelerating <= 1'b1;
            r_ticks_left   <= 8'd0;
            r_moving       <= 1'b0;
            r_coil         <= 6'd0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_direction    <= n_direction;
            r_total_steps  <= n_total_steps;
            r_step_number  <= n_step_number;
            r_cur_delay    <= n_cur_delay;
            r_accel_steps  <= n_accel_steps;
            r_accelerating <= n_accelerating;
            r_ticks_left   <= n_ticks_left;
            r_moving       <= n_moving;
            r_coil         <= n_coil;
        end
    end

    // result for this word
    always_comb begin
        o_result.coil_pattern = n_coil;
        o_result.step_taken   = do_step;
        o_result.busy_res     = n_moving;
        o_result.move_done    = done;
    end

    // a running move always has a hold pending
    a_hold_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> (r_ticks_left != 8'd0))
        else $error("move active with no hold ticks left");

    // step counter never passes the move length
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step_number <= r_total_steps)
        else $error("step number beyond move length");

    // each applied step advances the phase by exactly one
    a_phase_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && do_step) |=> (r_phase == $past(r_phase) + 2'd1))
        else $error("phase did not advance on step");

endmodule

`default_nettype wire

/* rtl/stepper_trapezoid_ramp_core.sv */
// top level of the trapezoid ramp stepper core: input register, engine, result register
// depends on str_pkg, str_cfg, str_engine
//
//  channel | direction | handshake                 | word
//  in      | to core   | i_in_valid / o_in_stall   | cmd, move_dir, step_count
//  out     | from core | o_out_valid / i_out_stall | coil_pattern, step_taken, busy_res, move_done
//  cfg     | to core   | i_cfg_valid / o_cfg_ready | register index, write data
//
// one word per cycle sustained while the result side does not stall; a taken word passes
// through the input register and, via the combinational state update, into the result register
// reset is synchronous, active low; no clearing pass
// a stall on the result side holds the result register, then the input register, then
// raises o_in_stall; configuration writes are always ready
`default_nettype none

module stepper_trapezoid_ramp_core #(
    parameter int STEP_COUNT_BITS = str_pkg::STEP_COUNT_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_cmd,
    input  wire logic                             i_move_dir,
    input  wire logic [STEP_COUNT_BITS-1:0]       i_step_count,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [5:0]                            o_coil_pattern,
    output logic                                  o_step_taken,
    output logic                                  o_busy_res,
    output logic                                  o_move_done,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [str_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [str_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    logic                       r_in_valid;
    logic                       r_cmd;
    logic                       r_dir;
    logic [STEP_COUNT_BITS-1:0] r_count;
    logic                       r_out_valid;
    str_pkg::t_result           r_result;

    logic                       advance;
    logic                       fire;
    logic [7:0]                 start_delay;
    logic [7:0]                 cruise_delay;
    str_pkg::t_result           eng_result;

    // pipeline control
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd   <= i_cmd;
            r_dir   <= i_move_dir;
            r_count <= i_step_count;
        end
    end

    // configuration registers
    str_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_cfg_ready    (o_cfg_ready),
        .o_start_delay  (start_delay),
        .o_cruise_delay (cruise_delay)
    );

    // move state and update
    str_engine #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_cmd          (r_cmd),
        .i_dir          (r_dir),
        .i_count        (r_count),
        .i_start_delay  (start_delay),
        .i_cruise_delay (cruise_delay),
        .o_result       (eng_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= eng_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_coil_pattern = r_result.coil_pattern;
    assign o_step_taken   = r_result.step_taken;
    assign o_busy_res     = r_result.busy_res;
    assign o_move_done    = r_result.move_done;

    // a word never both steps and finishes a move
    a_step_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_step_taken && o_move_done))
        else $error("step and move done on the same word");

    // a step always leaves the move running
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_step_taken) |-> o_busy_res)
        else $error("step reported with move idle");

    // a finished move reports idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_move_done) |-> !o_busy_res)
        else $error("move done reported while busy");

endmodule

`default_nettype wire

/* dv/str_ramp_monitor.sv */
// result checker for the trapezoid ramp stepper core: watches the three channels,
// runs its own ramp and coil predictor and compares every result word
// depends on str_pkg
`default_nettype none

module str_ramp_monitor #(
    parameter int CNT_W = str_pkg::STEP_COUNT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic                           i_cmd,
    input  wire logic                           i_move_dir,
    input  wire logic [CNT_W-1:0]               i_step_count,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [5:0]                     i_coil_pattern,
    input  wire logic                           i_step_taken,
    input  wire logic                           i_busy_res,
    input  wire logic                           i_move_done,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [str_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [str_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output logic                                o_motion_busy
);
    import str_pkg::*;

    // shadow copy of the delay registers
    logic [7:0] start_dly_q;
    logic [7:0] cruise_dly_q;

    // shadow copy of the ramp and sequencer state
    logic [1:0]       phase_q;
    logic             cw_q;
    logic [CNT_W-1:0] total_q;
    logic [CNT_W-1:0] done_steps_q;
    logic [7:0]       delay_q;
    logic [CNT_W-1:0] ramp_steps_q;
    logic             ramping_up_q;
    logic [7:0]       ticks_q;
    logic             moving_q;
    logic [5:0]       coil_q;

    // result words owed by the core, oldest first
    t_result coil_words_due[$];

    // apply the next coil pattern and work out the delay for the step after it
    task automatic advance_coil();
        logic [7:0]       next_delay;
        logic [7:0]       hold;
        logic [CNT_W-1:0] left;
        next_delay = delay_q;
        hold       = delay_q;
        left       = total_q - done_steps_q;
        if (ramping_up_q && next_delay > cruise_dly_q) begin
            next_delay   = next_delay - 8'd1;
            ramp_steps_q = ramp_steps_q + 1'b1;
        end else if (left > ramp_steps_q) begin
            // cruising, delay stays
        end else begin
            ramping_up_q = 1'b0;
            if (next_delay < DELAY_MAX)
                next_delay = next_delay + 8'd1;
        end
        // mirrored table order when turning counter-clockwise
        coil_q       = cw_q ? COIL_TABLE[phase_q] : COIL_TABLE[2'd3 - phase_q];
        phase_q      = phase_q + 2'd1;
        done_steps_q = done_steps_q + 1'b1;
        ticks_q      = (hold == 8'd0) ? 8'd1 : hold;
        delay_q      = next_delay;
    endtask

    // one accepted word: tick or start, giving the result word it causes
    task automatic ramp_update(input logic cmd, input logic dir, input logic [CNT_W-1:0] n,
                               output t_result res);
        res = '0;
        if (cmd == CMD_START) begin
            // a start during a move is dropped
            if (!moving_q) begin
                if (n == '0) begin
                    res.move_done = 1'b1;
                end else begin
                    cw_q         = dir;
                    total_q      = n;
                    done_steps_q = '0;
                    delay_q      = start_dly_q;
                    ramp_steps_q = '0;
                    ramping_up_q = 1'b1;
                    moving_q     = 1'b1;
                    advance_coil();
                    res.step_taken = 1'b1;
                end
            end
        end else if (moving_q) begin
            if (ticks_q > 8'd0)
                ticks_q = ticks_q - 8'd1;
            if (ticks_q == 8'd0) begin
                if (done_steps_q < total_q) begin
                    advance_coil();
                    res.step_taken = 1'b1;
                end else begin
                    moving_q      = 1'b0;
                    res.move_done = 1'b1;
                end
            end
        end
        res.coil_pattern = coil_q;
        res.busy_res     = moving_q;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endfunction

    // everything is sampled at the rising edge, inputs settle at the falling edge
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            start_dly_q  = START_DELAY_RST;
            cruise_dly_q = CRUISE_DELAY_RST;
            phase_q      = '0;
            cw_q         = 1'b0;
            total_q      = '0;
            done_steps_q = '0;
            delay_q      = '0;
            ramp_steps_q = '0;
            ramping_up_q = 1'b1;
            ticks_q      = '0;
            moving_q     = 1'b0;
            coil_q       = '0;
            o_fail_count = 0;
            coil_words_due.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_DELAY:  start_dly_q  = i_cfg_wdata;
                    CFG_CRUISE_DELAY: cruise_dly_q = i_cfg_wdata;
                    default: ;
                endcase
            end
            // accepted input word
            if (i_in_valid && !i_in_stall) begin
                ramp_update(i_cmd, i_move_dir, i_step_count, want);
                coil_words_due.push_back(want);
            end
            // accepted result word
            if (i_out_valid && !i_out_stall) begin
                if (coil_words_due.size() == 0) begin
                    $error("result word with none outstanding: coil_pattern %0d",
                           i_coil_pattern);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = coil_words_due.pop_front();
                    check_field("coil_pattern", want.coil_pattern, i_coil_pattern);
                    check_field("step_taken", want.step_taken, i_step_taken);
                    check_field("busy_res", want.busy_res, i_busy_res);
                    check_field("move_done", want.move_done, i_move_done);
                end
            end
        end
        o_pending     = coil_words_due.size();
        o_motion_busy = moving_q;
    end

endmodule

`default_nettype wire

/* dv/stepper_trapezoid_ramp_core_tb.sv */
// top of the trapezoid ramp stepper core bench: clock, reset, stimulus and verdict
// depends on str_pkg, stepper_trapezoid_ramp_core and str_ramp_monitor
`default_nettype none

module stepper_trapezoid_ramp_core_tb;
    import str_pkg::*;

    localparam int CNT_W         = STEP_COUNT_BITS_DEF;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int PHASE_WORDS   = 70;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int NUM_PHASES    = 9;

    logic                  i_clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  cmd;
    logic                  move_dir;
    logic [CNT_W-1:0]      step_count;
    logic                  out_valid;
    logic                  out_stall;
    logic [5:0]            coil_pattern;
    logic                  step_taken;
    logic                  busy_res;
    logic                  move_done;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int   fail_count;
    int   pending;
    logic motion_busy;
    int   cycle_count = 0;
    int   words_sent  = 0;
    bit   in_idle_on  = 1'b1;
    int   start_now   = START_DELAY_RST;

    // delay settings walked through by the random part, last one drawn at run time
    int start_tab[NUM_PHASES]  = '{1, 255, 3, 8, 40, 17, 2, 255, 1};
    int cruise_tab[NUM_PHASES] = '{1, 254, 1, 255, 2, 5, 2, 1, 1};

    stepper_trapezoid_ramp_core #(
        .STEP_COUNT_BITS(CNT_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_move_dir    (move_dir),
        .i_step_count  (step_count),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_coil_pattern(coil_pattern),
        .o_step_taken  (step_taken),
        .o_busy_res    (busy_res),
        .o_move_done   (move_done),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata)
    );

    str_ramp_monitor #(
        .CNT_W(CNT_W)
    ) ramp_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_move_dir    (move_dir),
        .i_step_count  (step_count),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_coil_pattern(coil_pattern),
        .i_step_taken  (step_taken),
        .i_busy_res    (busy_res),
        .i_move_done   (move_done),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_motion_busy (motion_busy)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run length guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stall before each word, some stretches with none
    initial begin : result_sink
        int wait_cycles;
        int taken;
        bit idle_on;
        out_stall = 1'b0;
        taken     = 0;
        idle_on   = 1'b1;
        @(negedge i_clk);
        forever begin
            if (taken % 29 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            wait_cycles = idle_on ? $urandom_range(0, 16) : 0;
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge i_clk);
                out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

    // present one word after a random gap and hold it until taken
    task automatic send_word(input logic c, input logic d, input logic [CNT_W-1:0] n);
        int gap;
        if (words_sent % 37 == 0)
            in_idle_on = ($urandom_range(0, 2) != 0);
        gap = in_idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        move_dir   <= d;
        step_count <= n;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // register write once the core has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // ticks with random unused fields, now and then a dropped start, until the move ends
    task automatic tick_until_idle();
        while (motion_busy) begin
            if ($urandom_range(0, 15) == 0)
                send_word(CMD_START, $urandom_range(0, 1), $urandom_range(0, 4095));
            else
                send_word(CMD_TICK, $urandom_range(0, 1), $urandom_range(0, 4095));
        end
    endtask

    task automatic drive_move(input logic d, input logic [CNT_W-1:0] n);
        send_word(CMD_START, d, n);
        tick_until_idle();
    endtask

    initial begin : stimulus
        int               pick;
        int               max_n;
        int               phase_base;
        logic [CNT_W-1:0] n;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = CMD_TICK;
        move_dir   = 1'b0;
        step_count = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_START_DELAY;
        cfg_wdata  = '0;
        repeat (5) @(negedge i_clk);
        rst_n <= 1'b1;

        // directed: idle tick, zero-length moves, dropped start, short and full ramps
        send_word(CMD_TICK, 1'b1, '1);
        send_word(CMD_START, 1'b1, '0);
        send_word(CMD_START, 1'b0, '0);
        send_word(CMD_START, 1'b1, 12'd2);
        send_word(CMD_START, 1'b0, '1);
        tick_until_idle();
        drive_move(1'b1, 12'd3);
        drive_move(1'b0, 12'd30);
        drive_move(1'b1, 12'd1);
        // long move at the fastest rate
        write_reg(CFG_START_DELAY, 8'd1);
        write_reg(CFG_CRUISE_DELAY, 8'd1);
        drive_move(1'b0, 12'd60);

        // random moves across the delay settings
        start_tab[NUM_PHASES-1]  = $urandom_range(1, 255);
        cruise_tab[NUM_PHASES-1] = $urandom_range(1, 255);
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_START_DELAY, start_tab[p]);
            write_reg(CFG_CRUISE_DELAY, cruise_tab[p]);
            start_now  = start_tab[p];
            phase_base = words_sent;
            // slow settings get only very short moves
            max_n = (start_now > 32) ? 1 : 20;
            while (words_sent - phase_base < PHASE_WORDS) begin
                pick = $urandom_range(0, 31);
                if (pick == 0)
                    n = '0;
                else if (pick == 1 && start_now <= 3)
                    n = $urandom_range(64, 160);
                else
                    n = $urandom_range(1, max_n);
                drive_move($urandom_range(0, 1), n);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_word(CMD_TICK, $urandom_range(0, 1), $urandom_range(0, 4095));
            end
        end

        // drain and settle
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
